FILE: rtl/qpd_pkg.sv
// Shared types, constants and ordering function for the two-queue dispatcher.
`default_nettype none

package qpd_pkg;

  // Input mode codes
  localparam logic MODE_ENQ  = 1'b0;
  localparam logic MODE_DISP = 1'b1;

  // Direction codes
  localparam logic DIR_EAST = 1'b0;
  localparam logic DIR_WEST = 1'b1;

  localparam int unsigned LOAD_W  = 10;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] STARVE_LIMIT_RST = LIMIT_W'(3);
  localparam logic [LIMIT_W-1:0] GRANTS_MAX       = '1;

  // Direction of the most recent grant
  typedef enum logic [1:0] {
    LAST_NONE = 2'd0,
    LAST_EAST = 2'd1,
    LAST_WEST = 2'd2
  } last_dir_t;

  // One queued request, {prio, load_time, id}
  typedef struct packed {
    logic              prio;
    logic [LOAD_W-1:0] load;
    logic [ID_W-1:0]   id;
  } entry_t;

  // What a cell shows its neighbors
  typedef struct packed {
    entry_t entry;
    logic   occ;
    logic   cond;   // new request goes at or before this slot
  } cell_link_t;

  // One result
  typedef struct packed {
    logic            grant_valid;
    logic            grant_west;
    logic [ID_W-1:0] grant_id;
    logic            queue_full;
  } result_t;

  // True when a strictly sorts ahead of b
  function automatic logic beats(input entry_t a, input entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = a.prio;
    end else if (a.load != b.load) begin
      r = (a.load < b.load);
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/qpd_cell.sv
// One slot of a sorted shift-insert queue.
`default_nettype none

module qpd_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qpd_pkg::entry_t     new_entry,
  input  wire logic               ins_en,
  input  wire logic               pop_en,
  input  wire qpd_pkg::cell_link_t prev_link,
  input  wire qpd_pkg::cell_link_t next_link,
  output qpd_pkg::cell_link_t      link
);
  import qpd_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   occ_r, occ_nxt;
  logic   cond;

  // Insert point is the first slot that is empty or beaten by the new request
  assign cond = !occ_r || beats(new_entry, entry_r);

  assign link.entry = entry_r;
  assign link.occ   = occ_r;
  assign link.cond  = cond;

  // Next slot contents: take new, shift from ahead, shift from behind, or hold
  always_comb begin
    entry_nxt = entry_r;
    occ_nxt   = occ_r;
    priority if (ins_en) begin
      if (cond && !prev_link.cond) begin
        entry_nxt = new_entry;
        occ_nxt   = 1'b1;
      end else if (cond) begin
        entry_nxt = prev_link.entry;
        occ_nxt   = prev_link.occ;
      end
    end else if (pop_en) begin
      entry_nxt = next_link.entry;
      occ_nxt   = next_link.occ;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qpd_queue.sv
// Sorted request queue built as a row of shift-insert cells.
`default_nettype none

module qpd_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire qpd_pkg::entry_t new_entry,
  input  wire logic           ins_en,
  input  wire logic           pop_en,
  output qpd_pkg::entry_t      head,
  output logic                busy,
  output logic                full
);
  import qpd_pkg::*;

  cell_link_t links [DEPTH];
  cell_link_t edge_link;

  // Boundary seen ahead of the head and behind the tail
  assign edge_link = '{entry: '0, occ: 1'b0, cond: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t prev_l, next_l;
    if (i == 0) begin : g_first
      assign prev_l = edge_link;
    end else begin : g_mid
      assign prev_l = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_l = edge_link;
    end else begin : g_rest
      assign next_l = links[i+1];
    end
    qpd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .new_entry (new_entry),
      .ins_en    (ins_en),
      .pop_en    (pop_en),
      .prev_link (prev_l),
      .next_link (next_l),
      .link      (links[i])
    );
  end

  assign head = links[0].entry;
  assign busy = links[0].occ;
  assign full = links[DEPTH-1].occ;

endmodule

`default_nettype wire

FILE: rtl/two_queue_priority_dispatcher_unit.sv
// Top level: two sorted queues, dispatch arbiter and result buffer.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | mode, to_west, high_prio, load_time, req_id
//   out_    | output    | out_valid/out_stall| grant_valid, grant_west, grant_id, queue_full
//   cfg_    | input     | cfg_wr_en          | cfg_wr_data (starve_limit)
//
// Each request is handled in the cycle it is accepted: every cell compares
// against the new request in parallel and hands its entry to a neighbor.
// One request per cycle while in_stall is low; the result reaches out_ in the cycle after
// acceptance when the output register is free, else it waits in the skid register.
// A two-entry result buffer keeps in_stall low until two results wait.
// Synchronous reset empties both queues and sets starve_limit to 3.
`default_nettype none

module two_queue_priority_dispatcher_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_mode,
  input  wire logic                        in_to_west,
  input  wire logic                        in_high_prio,
  input  wire logic [qpd_pkg::LOAD_W-1:0]  in_load_time,
  input  wire logic [qpd_pkg::ID_W-1:0]    in_req_id,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_grant_valid,
  output logic                             out_grant_west,
  output logic [qpd_pkg::ID_W-1:0]         out_grant_id,
  output logic                             out_queue_full,
  input  wire logic                        cfg_wr_en,
  input  wire logic [qpd_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import qpd_pkg::*;

  logic                 accept;
  entry_t               new_entry;
  entry_t               east_head, west_head;
  logic                 east_busy, west_busy, east_full, west_full;
  logic                 east_ins, west_ins, east_pop, west_pop;
  logic                 is_disp, any_busy, pick_west;
  logic                 clr_east, clr_west;
  logic [LIMIT_W-1:0]   starve_limit_r;
  logic [LIMIT_W-1:0]   east_grants_r, east_grants_nxt;
  logic [LIMIT_W-1:0]   west_grants_r, west_grants_nxt;
  last_dir_t            last_dir_r, last_dir_nxt;
  result_t              res;
  result_t              out_r, skid_r;
  logic                 out_valid_r, skid_valid_r;
  logic                 out_take;

  assign accept    = in_valid && !in_stall;
  assign is_disp   = (in_mode == MODE_DISP);
  assign new_entry = '{prio: in_high_prio, load: in_load_time, id: in_req_id};

  // Queues
  qpd_queue #(.DEPTH(QUEUE_DEPTH)) u_east (
    .clk (clk), .rst_n (rst_n), .new_entry (new_entry),
    .ins_en (east_ins), .pop_en (east_pop),
    .head (east_head), .busy (east_busy), .full (east_full)
  );

  qpd_queue #(.DEPTH(QUEUE_DEPTH)) u_west (
    .clk (clk), .rst_n (rst_n), .new_entry (new_entry),
    .ins_en (west_ins), .pop_en (west_pop),
    .head (west_head), .busy (west_busy), .full (west_full)
  );

  // Dispatch choice: lone queue, starvation yield (east first), priority, alternation
  always_comb begin
    pick_west = 1'b0;
    clr_east  = 1'b0;
    clr_west  = 1'b0;
    priority if (!east_busy) begin
      pick_west = 1'b1;
    end else if (!west_busy) begin
      pick_west = 1'b0;
    end else if (east_grants_r >= starve_limit_r) begin
      pick_west = 1'b1;
      clr_east  = 1'b1;
    end else if (west_grants_r >= starve_limit_r) begin
      pick_west = 1'b0;
      clr_west  = 1'b1;
    end else if (east_head.prio != west_head.prio) begin
      pick_west = west_head.prio;
    end else begin
      pick_west = (last_dir_r != LAST_WEST);
    end
  end

  assign any_busy = east_busy || west_busy;

  // Queue controls
  assign east_ins = accept && !is_disp && (in_to_west == DIR_EAST) && !east_full;
  assign west_ins = accept && !is_disp && (in_to_west == DIR_WEST) && !west_full;
  assign east_pop = accept && is_disp && any_busy && !pick_west;
  assign west_pop = accept && is_disp && any_busy && pick_west;

  // Grant counters and last direction
  always_comb begin
    east_grants_nxt = east_grants_r;
    west_grants_nxt = west_grants_r;
    last_dir_nxt    = last_dir_r;
    if (east_pop || west_pop) begin
      if (clr_east) begin
        east_grants_nxt = '0;
      end
      if (clr_west) begin
        west_grants_nxt = '0;
      end
      if (west_pop) begin
        if (west_grants_nxt != GRANTS_MAX) begin
          west_grants_nxt = west_grants_nxt + LIMIT_W'(1);
        end
        last_dir_nxt = LAST_WEST;
      end else begin
        if (east_grants_nxt != GRANTS_MAX) begin
          east_grants_nxt = east_grants_nxt + LIMIT_W'(1);
        end
        last_dir_nxt = LAST_EAST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      east_grants_r  <= '0;
      west_grants_r  <= '0;
      last_dir_r     <= LAST_NONE;
      starve_limit_r <= STARVE_LIMIT_RST;
    end else begin
      east_grants_r <= east_grants_nxt;
      west_grants_r <= west_grants_nxt;
      last_dir_r    <= last_dir_nxt;
      if (cfg_wr_en) begin
        starve_limit_r <= cfg_wr_data;
      end
    end
  end

  // Result of the accepted request
  always_comb begin
    res.grant_valid = is_disp && any_busy;
    res.grant_west  = is_disp && any_busy && pick_west;
    res.grant_id    = '0;
    res.queue_full  = 1'b0;
    if (is_disp) begin
      if (any_busy) begin
        res.grant_id = pick_west ? west_head.id : east_head.id;
      end
    end else begin
      res.queue_full = (in_to_west == DIR_WEST) ? west_full : east_full;
    end
  end

  // Two-entry result buffer: output register plus skid register
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_grant_valid = out_r.grant_valid;
  assign out_grant_west  = out_r.grant_west;
  assign out_grant_id    = out_r.grant_id;
  assign out_queue_full  = out_r.queue_full;

endmodule

`default_nettype wire

FILE: rtl/qpd_checker.sv
// Port-level checks for the two-queue dispatcher, bound to the top level.
`default_nettype none

module qpd_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       out_grant_valid,
  input wire logic                       out_grant_west,
  input wire logic [qpd_pkg::ID_W-1:0]   out_grant_id,
  input wire logic                       out_queue_full
);
  import qpd_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Input is only held off while results back up
  a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A grant and a refused enqueue never share one result
  a_grant_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_grant_valid && out_queue_full))
    else $error("grant and queue full together");

  // No grant means empty grant fields
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_grant_valid |-> !out_grant_west && (out_grant_id == '0))
    else $error("grant fields set without a grant");

endmodule

bind two_queue_priority_dispatcher_unit qpd_checker u_qpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_grant_valid (out_grant_valid),
  .out_grant_west  (out_grant_west),
  .out_grant_id    (out_grant_id),
  .out_queue_full  (out_queue_full)
);

`default_nettype wire
